FILE: rtl/gcma_pkg.sv
// ----------------------------------------------------------------------------
// gcma_pkg
// widths, types and progeny code tables for the cross mean accumulator
// ----------------------------------------------------------------------------
package gcma_pkg;

   localparam int PARENT_W = 11;
   localparam int DOSAGE_W = 3;
   localparam int PLOIDY_W = 3;
   localparam int EFFECT_W = 32;
   localparam int CODE_W   = 18;                  // signed q1.16, spans -1.0 .. +1.0
   localparam int PROD_W   = CODE_W + EFFECT_W;   // signed q.32 product
   localparam int MIX_W    = PROD_W + 1;          // sum of the two products
   localparam int TERM_W   = MIX_W - 16;          // locus term back in q.16
   localparam int SUM_W    = 56;                  // signed q39.16 running sum

   localparam logic [PLOIDY_W-1:0] PLOIDY_DIPLOID    = 3'd2;
   localparam logic [PLOIDY_W-1:0] PLOIDY_TETRAPLOID = 3'd4;
   localparam logic [PLOIDY_W-1:0] PLOIDY_HEXAPLOID  = 3'd6;
   localparam logic [PLOIDY_W-1:0] PLOIDY_RESET      = PLOIDY_DIPLOID;

   localparam logic [MIX_W-1:0] ROUND_HALF = MIX_W'(32768);

   typedef logic [PARENT_W-1:0]        parent_type;
   typedef logic [DOSAGE_W-1:0]        dosage_type;
   typedef logic signed [EFFECT_W-1:0] effect_type;
   typedef logic signed [CODE_W-1:0]   code_type;
   typedef logic signed [SUM_W-1:0]    sum_type;

   // expected additive code, depends only on ploidy and the dosage sum
   function automatic code_type add_code(input logic [PLOIDY_W-1:0] ploidy,
                                         input logic [3:0] dsum);
      code_type c;
      c = '0;
      case (ploidy)
         PLOIDY_DIPLOID: begin
            case (dsum)
               4'd0:    c = -18'sd65536;
               4'd1:    c = -18'sd32768;
               4'd3:    c = 18'sd32768;
               4'd4:    c = 18'sd65536;
               default: c = '0;
            endcase
         end
         PLOIDY_TETRAPLOID: begin
            case (dsum)
               4'd0:    c = -18'sd65536;
               4'd1:    c = -18'sd49152;
               4'd2:    c = -18'sd32768;
               4'd3:    c = -18'sd16384;
               4'd5:    c = 18'sd16384;
               4'd6:    c = 18'sd32768;
               4'd7:    c = 18'sd49152;
               4'd8:    c = 18'sd65536;
               default: c = '0;
            endcase
         end
         PLOIDY_HEXAPLOID: begin
            case (dsum)
               4'd0:    c = -18'sd65536;
               4'd1:    c = -18'sd54613;
               4'd2:    c = -18'sd43691;
               4'd3:    c = -18'sd32768;
               4'd4:    c = -18'sd21845;
               4'd5:    c = -18'sd10923;
               4'd7:    c = 18'sd10923;
               4'd8:    c = 18'sd21845;
               4'd9:    c = 18'sd32768;
               4'd10:   c = 18'sd43691;
               4'd11:   c = 18'sd54613;
               4'd12:   c = 18'sd65536;
               default: c = '0;
            endcase
         end
         default: c = '0;
      endcase
      return c;
   endfunction

   // expected dominance code, keyed by {smaller dosage, larger dosage}
   function automatic code_type dom_code(input logic [PLOIDY_W-1:0] ploidy,
                                         input dosage_type lo,
                                         input dosage_type hi);
      code_type   c;
      logic [5:0] key;
      c   = '0;
      key = {lo, hi};
      case (ploidy)
         PLOIDY_DIPLOID: begin
            case (key)
               6'o01, 6'o11, 6'o12: c = 18'sd32768;
               6'o02:               c = 18'sd65536;
               default:             c = '0;
            endcase
         end
         PLOIDY_TETRAPLOID: begin
            case (key)
               6'o01, 6'o34:               c = 18'sd24576;
               6'o02, 6'o24:               c = 18'sd43691;
               6'o03, 6'o13, 6'o14:        c = 18'sd57344;
               6'o04:                      c = 18'sd65536;
               6'o11, 6'o33:               c = 18'sd40960;
               6'o12, 6'o23:               c = 18'sd51883;
               6'o22:                      c = 18'sd54613;
               default:                    c = '0;
            endcase
         end
         PLOIDY_HEXAPLOID: begin
            case (key)
               6'o01, 6'o56:               c = 18'sd18204;
               6'o02, 6'o46:               c = 18'sd33496;
               6'o03, 6'o36:               c = 18'sd45875;
               6'o04, 6'o26:               c = 18'sd55342;
               6'o05, 6'o15, 6'o16:        c = 18'sd61895;
               6'o06:                      c = 18'sd65536;
               6'o11, 6'o55:               c = 18'sd32768;
               6'o12, 6'o45:               c = 18'sd44419;
               6'o13, 6'o35:               c = 18'sd53157;
               6'o14, 6'o25, 6'o33:        c = 18'sd58982;
               6'o22, 6'o44:               c = 18'sd52429;
               6'o23, 6'o34:               c = 18'sd57526;
               6'o24:                      c = 18'sd59711;
               default:                    c = '0;
            endcase
         end
         default: c = '0;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/gcma_req_if.sv
// ----------------------------------------------------------------------------
// gcma_req_if
// locus request channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface gcma_req_if
   import gcma_pkg::*;
();
   logic       valid;
   logic       ready;
   parent_type first_parent;
   parent_type second_parent;
   dosage_type first_dosage;
   dosage_type second_dosage;
   effect_type additive_effect;
   effect_type dominance_effect;
   logic       last_locus;

   modport source (
      output valid, first_parent, second_parent, first_dosage, second_dosage,
             additive_effect, dominance_effect, last_locus,
      input  ready
   );
   modport sink (
      input  valid, first_parent, second_parent, first_dosage, second_dosage,
             additive_effect, dominance_effect, last_locus,
      output ready
   );
endinterface

FILE: rtl/gcma_rsp_if.sv
// ----------------------------------------------------------------------------
// gcma_rsp_if
// cross mean result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface gcma_rsp_if
   import gcma_pkg::*;
();
   logic       valid;
   logic       ready;
   parent_type parent_a;
   parent_type parent_b;
   sum_type    cross_mean;
   logic       error_flag;

   modport source (
      output valid, parent_a, parent_b, cross_mean, error_flag,
      input  ready
   );
   modport sink (
      input  valid, parent_a, parent_b, cross_mean, error_flag,
      output ready
   );
endinterface

FILE: rtl/genomic_cross_mean_accumulator_top.sv
// ----------------------------------------------------------------------------
// genomic_cross_mean_accumulator_top
// streams loci of one cross, accumulates additive plus dominance effects
// weighted by expected progeny codes, emits the predicted cross mean
// ----------------------------------------------------------------------------
//  channel    direction  handshake          carries
//  req_chan   in         valid / ready      parents, dosages, effects, last mark
//  rsp_chan   out        valid / ready      parents echo, cross mean, error flag
//  csr_*      in         write enable only  ploidy (3 bits)
//
//  one request per cycle while no last locus waits on a stalled result; a result
//  shows on rsp_chan once the last locus has passed lookup+multiply, round, accumulate
//  reset is synchronous, active high: ploidy back to 2, sum and error cleared
//  a stalled result holds only the output register; loci without the last
//  mark keep flowing through the accumulator behind it
//  the user (not the block) sees that ploidy is written only while the pipeline is empty
// ----------------------------------------------------------------------------
module genomic_cross_mean_accumulator_top
   import gcma_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   gcma_req_if.sink            req_chan,
   gcma_rsp_if.source          rsp_chan,
   input  logic                csr_write_enable,
   input  logic [PLOIDY_W-1:0] csr_write_data
);

   // ploidy register
   logic [PLOIDY_W-1:0] ploidy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ploidy_ff <= PLOIDY_RESET;
      end else if (csr_write_enable) begin
         ploidy_ff <= csr_write_data;
      end
   end

   // stage 1: registered request
   logic       s1_valid_ff, s1_valid_in;
   parent_type s1_parent_a_ff, s1_parent_b_ff;
   dosage_type s1_dosage_a_ff, s1_dosage_b_ff;
   effect_type s1_add_eff_ff, s1_dom_eff_ff;
   logic       s1_last_ff;

   // stage 2: products
   logic                     s2_valid_ff, s2_valid_in;
   parent_type               s2_parent_a_ff, s2_parent_b_ff;
   logic signed [PROD_W-1:0] s2_prod_add_ff, s2_prod_dom_ff;
   logic                     s2_error_ff, s2_last_ff;

   // stage 3: rounded locus term
   logic                     s3_valid_ff, s3_valid_in;
   parent_type               s3_parent_a_ff, s3_parent_b_ff;
   logic signed [TERM_W-1:0] s3_term_ff;
   logic                     s3_error_ff, s3_last_ff;

   // accumulator and result register
   sum_type    sum_ff, sum_in;
   logic       sticky_ff, sticky_in;
   logic       rsp_valid_ff, rsp_valid_in;
   parent_type rsp_parent_a_ff, rsp_parent_b_ff;
   sum_type    rsp_mean_ff;
   logic       rsp_error_ff;

   // flow control: a waiting result stalls a last locus at stage 3 and the stages behind it
   logic out_free, mv3, rdy3, mv2, rdy2, mv1, rdy1, req_take;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign mv3      = s3_valid_ff && (!s3_last_ff || out_free);
   assign rdy3     = !s3_valid_ff || mv3;
   assign mv2      = s2_valid_ff && rdy3;
   assign rdy2     = !s2_valid_ff || rdy3;
   assign mv1      = s1_valid_ff && rdy2;
   assign rdy1     = !s1_valid_ff || rdy2;
   assign req_take = req_chan.valid && rdy1;

   assign req_chan.ready = rdy1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (mv1) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (mv1) begin
         s2_valid_in = 1'b1;
      end else if (mv2) begin
         s2_valid_in = 1'b0;
      end
      s3_valid_in = s3_valid_ff;
      if (mv2) begin
         s3_valid_in = 1'b1;
      end else if (mv3) begin
         s3_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_parent_a_ff <= req_chan.first_parent;
         s1_parent_b_ff <= req_chan.second_parent;
         s1_dosage_a_ff <= req_chan.first_dosage;
         s1_dosage_b_ff <= req_chan.second_dosage;
         s1_add_eff_ff  <= req_chan.additive_effect;
         s1_dom_eff_ff  <= req_chan.dominance_effect;
         s1_last_ff     <= req_chan.last_locus;
      end
   end

   // code lookup and the two multiplies
   logic                     supported, s1_error;
   dosage_type               dose_lo, dose_hi;
   code_type                 code_add, code_dom;
   logic signed [PROD_W-1:0] prod_add, prod_dom;

   assign supported = (ploidy_ff == PLOIDY_DIPLOID) || (ploidy_ff == PLOIDY_TETRAPLOID)
                   || (ploidy_ff == PLOIDY_HEXAPLOID);
   assign s1_error  = !supported || (s1_dosage_a_ff > ploidy_ff)
                   || (s1_dosage_b_ff > ploidy_ff);

   // dominance table is symmetric, key it on the ordered pair
   assign dose_lo = (s1_dosage_a_ff < s1_dosage_b_ff) ? s1_dosage_a_ff : s1_dosage_b_ff;
   assign dose_hi = (s1_dosage_a_ff < s1_dosage_b_ff) ? s1_dosage_b_ff : s1_dosage_a_ff;

   assign code_add = add_code(ploidy_ff, 4'(s1_dosage_a_ff) + 4'(s1_dosage_b_ff));
   assign code_dom = dom_code(ploidy_ff, dose_lo, dose_hi);

   assign prod_add = PROD_W'(code_add) * PROD_W'(s1_add_eff_ff);
   assign prod_dom = PROD_W'(code_dom) * PROD_W'(s1_dom_eff_ff);

   always_ff @(posedge clock) begin
      if (mv1) begin
         s2_parent_a_ff <= s1_parent_a_ff;
         s2_parent_b_ff <= s1_parent_b_ff;
         s2_prod_add_ff <= prod_add;
         s2_prod_dom_ff <= prod_dom;
         s2_error_ff    <= s1_error;
         s2_last_ff     <= s1_last_ff;
      end
   end

   // q.32 to q.16, round half up via floor of (x + 1/2)
   logic signed [MIX_W-1:0] mix;

   assign mix = MIX_W'(s2_prod_add_ff) + MIX_W'(s2_prod_dom_ff) + $signed(ROUND_HALF);

   always_ff @(posedge clock) begin
      if (mv2) begin
         s3_parent_a_ff <= s2_parent_a_ff;
         s3_parent_b_ff <= s2_parent_b_ff;
         s3_term_ff     <= mix[MIX_W-1:16];
         s3_error_ff    <= s2_error_ff;
         s3_last_ff     <= s2_last_ff;
      end
   end

   // saturating accumulate; overflow shows as disagreement of the top two bits
   logic signed [SUM_W:0] wide_sum;
   sum_type               sat_sum, next_sum;
   logic                  next_sticky;

   assign wide_sum = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(s3_term_ff);

   always_comb begin
      if (wide_sum[SUM_W] == wide_sum[SUM_W-1]) begin
         sat_sum = wide_sum[SUM_W-1:0];
      end else if (wide_sum[SUM_W]) begin
         sat_sum = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         sat_sum = {1'b0, {(SUM_W-1){1'b1}}};
      end
   end

   // an erroneous locus leaves the sum alone
   assign next_sum    = s3_error_ff ? sum_ff : sat_sum;
   assign next_sticky = sticky_ff || s3_error_ff;

   always_comb begin
      sum_in       = sum_ff;
      sticky_in    = sticky_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (mv3) begin
         if (s3_last_ff) begin
            // cross done: publish and start the next cross from zero
            sum_in       = '0;
            sticky_in    = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            sum_in    = next_sum;
            sticky_in = next_sticky;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         sticky_ff    <= sticky_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mv3 && s3_last_ff) begin
         rsp_parent_a_ff <= s3_parent_a_ff;
         rsp_parent_b_ff <= s3_parent_b_ff;
         rsp_mean_ff     <= next_sticky ? '0 : next_sum;
         rsp_error_ff    <= next_sticky;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.parent_a   = rsp_parent_a_ff;
   assign rsp_chan.parent_b   = rsp_parent_b_ff;
   assign rsp_chan.cross_mean = rsp_mean_ff;
   assign rsp_chan.error_flag = rsp_error_ff;

   // a flagged cross never reports a mean
   a_error_zero_mean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_error_ff |-> rsp_mean_ff == '0)
      else $error("flagged result carries a nonzero mean");

   // the accumulator starts clean after a cross is published
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      mv3 && s3_last_ff |=> sum_ff == '0 && !sticky_ff)
      else $error("accumulator not cleared after last locus");

   // a last locus never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !(mv3 && s3_last_ff))
      else $error("pending result overwritten");

   // an accepted request lands in stage 1
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted request lost at stage 1");

endmodule
